[hdl/mppd_pkg.sv]
package mppd_pkg;

  // Encoder and current scaling
  localparam int unsigned TicksPerTurn       = 8192;
  localparam int unsigned CurrentMax         = 16384;
  localparam int unsigned FirstFeedbackTicks = 500;
  localparam int unsigned FrameMinLength     = 7;
  localparam int unsigned ToleranceDefault   = (TicksPerTurn + 50) / 100;

  // Q16.16 arithmetic
  localparam int unsigned FracBits  = 16;
  localparam int unsigned PSatShift = 48;
  localparam int unsigned CmdW      = 51;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_MOVING      = 3'd1,
    ST_REACHED     = 3'd2,
    ST_TIMEOUT     = 3'd3,
    ST_LOST        = 3'd4,
    ST_NO_FEEDBACK = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_GAIN_POSITION = 3'd0,
    REG_GAIN_VELOCITY = 3'd1,
    REG_BIAS_CURRENT  = 3'd2,
    REG_CURRENT_LIMIT = 3'd3,
    REG_TOLERANCE     = 3'd4,
    REG_SETTLE        = 3'd5,
    REG_TIMEOUT       = 3'd6,
    REG_STALE         = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic signed [31:0] gain_position;
    logic signed [31:0] gain_velocity;
    logic signed [15:0] bias_current;
    logic [14:0]        current_limit;
    logic [13:0]        tolerance_ticks;
    logic [15:0]        settle_ticks;
    logic [23:0]        timeout_ticks;
    logic [15:0]        stale_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         frame_length;
    logic [12:0]        encoder;
    logic signed [15:0] rpm;
    logic signed [31:0] target_ticks;
  } item_t;

  // Handoff from the state update to the current computation
  typedef struct packed {
    logic               cmd_en;
    logic               run_law;
    logic               far;
    logic               err_pos;
    status_e            status;
    logic [31:0]        position;
    logic signed [64:0] p_prod;
    logic signed [47:0] d_prod;
  } stage_t;

endpackage

[hdl/motor_position_pd_with_encoder_unwrap_top.sv]
// Position controller for one motor with a wrapping absolute encoder.
//
// Input channel (in_valid_i / in_ready_o): each item is a feedback frame, a
// control tick or a move start, selected by action_i. Frames of at least seven
// bytes unwrap the encoder into a signed tick total; the first frame only seeds
// tracking. A start waits for a fresh frame, then the next tick zeroes the
// reference and the PD law runs from there.
// Output channel (out_valid_o / out_ready_i): exactly one result per item:
// command flag, Q16.16 PD current rounded and clipped, move status and the
// position relative to the move reference.
// Configuration: write cfg_data_i to register cfg_index_i with cfg_we_i; do
// this only while no item is in flight.
// Pipeline: the item register feeds the state update and the two gain
// multipliers into the stage register, and the current finish stage loads the
// output register from it.
// One item per cycle is sustained with no stall from the receiver.
// Reset clears all tracking and move state and loads register defaults.
// When the receiver stalls, items queue in the three stages and in_ready_o
// drops only once all of them are full.
module motor_position_pd_with_encoder_unwrap_top import mppd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         frame_length_i,
  input  logic [12:0]        encoder_i,
  input  logic signed [15:0] rpm_i,
  input  logic signed [31:0] target_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               command_valid_o,
  output logic signed [15:0] command_current_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] position_ticks_o
);

  cfg_t   cfg;
  item_t  item_q;
  stage_t stage;

  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic               out_ld, s2_ld, s1_ld, go;
  logic signed [15:0] law_current;

  logic               cmd_valid_q;
  logic signed [15:0] current_q;
  logic [2:0]         status_q;
  logic [31:0]        position_q;

  // Advance a stage when the one after it is empty or moving on
  assign out_ld     = !out_valid_q || out_ready_i;
  assign s2_ld      = !s2_valid_q || out_ld;
  assign s1_ld      = !s1_valid_q || s2_ld;
  assign in_ready_o = s1_ld;
  assign go         = s1_valid_q && s2_ld;

  mppd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mppd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .stage_o (stage)
  );

  mppd_law u_law (
    .stage_i   (stage),
    .cfg_i     (cfg),
    .current_o (law_current)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ld) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ld) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Capture the item on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ld) begin
      item_q.action       <= action_i;
      item_q.frame_length <= frame_length_i;
      item_q.encoder      <= encoder_i;
      item_q.rpm          <= rpm_i;
      item_q.target_ticks <= target_ticks_i;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (out_ld && s2_valid_q) begin
      cmd_valid_q <= stage.cmd_en;
      current_q   <= law_current;
      status_q    <= stage.status;
      position_q  <= stage.position;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_valid_o   = cmd_valid_q;
  assign command_current_o = current_q;
  assign status_o          = status_q;
  assign position_ticks_o  = $signed(position_q);

endmodule

[hdl/mppd_cfg.sv]
module mppd_cfg import mppd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        REG_GAIN_POSITION: cfg_d.gain_position   = $signed(cfg_data_i);
        REG_GAIN_VELOCITY: cfg_d.gain_velocity   = $signed(cfg_data_i);
        REG_BIAS_CURRENT:  cfg_d.bias_current    = $signed(cfg_data_i[15:0]);
        REG_CURRENT_LIMIT: cfg_d.current_limit   = cfg_data_i[14:0];
        REG_TOLERANCE:     cfg_d.tolerance_ticks = cfg_data_i[13:0];
        REG_SETTLE:        cfg_d.settle_ticks    = cfg_data_i[15:0];
        REG_TIMEOUT:       cfg_d.timeout_ticks   = cfg_data_i[23:0];
        REG_STALE:         cfg_d.stale_ticks     = cfg_data_i[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_position   <= '0;
      cfg_q.gain_velocity   <= '0;
      cfg_q.bias_current    <= '0;
      cfg_q.current_limit   <= 15'd16384;
      cfg_q.tolerance_ticks <= 14'd82;
      cfg_q.settle_ticks    <= '0;
      cfg_q.timeout_ticks   <= 24'd2000;
      cfg_q.stale_ticks     <= 16'd150;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/mppd_ctrl.sv]
module mppd_ctrl import mppd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   go_i,
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output stage_t stage_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_MOVE
  } phase_e;

  localparam logic signed [17:0] HalfTurn = 18'(TicksPerTurn / 2);
  localparam logic signed [17:0] FullTurn = 18'(TicksPerTurn);

  logic               tracking_q, tracking_d;
  logic [12:0]        prev_enc_q, prev_enc_d;
  logic [31:0]        total_q, total_d;
  logic [31:0]        ref_q, ref_d;
  logic [31:0]        rel_q, rel_d;
  logic signed [15:0] rpm_q, rpm_d;
  phase_e             phase_q, phase_d;
  logic signed [31:0] target_q, target_d;
  logic [23:0]        elapsed_q, elapsed_d;
  logic [16:0]        settle_q, settle_d;
  logic [15:0]        tsf_q, tsf_d;
  logic               fresh_q, fresh_d;
  stage_t             stage_q, stage_d;

  logic signed [17:0] enc_delta, enc_step;
  logic signed [32:0] err;
  logic [32:0]        aerr;
  logic [13:0]        tol;
  logic               in_band, far, stale, reached;

  // Unwrap: a jump of more than half a turn is a wrap
  assign enc_delta = $signed({5'b0, item_i.encoder}) - $signed({5'b0, prev_enc_q});
  always_comb begin
    enc_step = enc_delta;
    if (enc_delta > HalfTurn) begin
      enc_step = enc_delta - FullTurn;
    end else if (enc_delta < -HalfTurn) begin
      enc_step = enc_delta + FullTurn;
    end
  end

  // Error as seen by a tick; a tick that starts motion sees position zero
  assign err  = (phase_q == PH_WAIT && fresh_q) ? 33'(target_q)
                                                : 33'(target_q) - 33'($signed(rel_q));
  assign aerr = err[32] ? 33'(-err) : 33'(err);
  assign tol  = (cfg_i.tolerance_ticks != '0) ? cfg_i.tolerance_ticks
                                              : 14'(ToleranceDefault);
  assign in_band = aerr <= 33'(tol);
  assign far     = {aerr, 1'b0} > 34'(tol);
  assign stale   = tsf_q >= cfg_i.stale_ticks;

  always_comb begin
    tracking_d = tracking_q;
    prev_enc_d = prev_enc_q;
    total_d    = total_q;
    ref_d      = ref_q;
    rel_d      = rel_q;
    rpm_d      = rpm_q;
    phase_d    = phase_q;
    target_d   = target_q;
    elapsed_d  = elapsed_q;
    settle_d   = settle_q;
    tsf_d      = tsf_q;
    fresh_d    = fresh_q;
    reached    = 1'b0;

    stage_d.cmd_en  = 1'b0;
    stage_d.run_law = 1'b0;
    stage_d.far     = far;
    stage_d.err_pos = !err[32];
    stage_d.status  = (phase_q != PH_IDLE) ? ST_MOVING : ST_IDLE;
    stage_d.p_prod  = 65'($signed(cfg_i.gain_position)) * 65'(err);
    stage_d.d_prod  = 48'($signed(cfg_i.gain_velocity)) * 48'(rpm_q);

    case (action_e'(item_i.action))
      ACT_FRAME: begin
        if (item_i.frame_length >= 4'(FrameMinLength)) begin
          if (!tracking_q) begin
            tracking_d = 1'b1;
            total_d    = '0;
            ref_d      = '0;
            rel_d      = '0;
          end else begin
            total_d = total_q + 32'(enc_step);
            rel_d   = total_d - ref_q;
          end
          prev_enc_d = item_i.encoder;
          rpm_d      = item_i.rpm;
          tsf_d      = '0;
          fresh_d    = 1'b1;
        end
      end
      ACT_START: begin
        target_d       = item_i.target_ticks;
        phase_d        = PH_WAIT;
        elapsed_d      = '0;
        settle_d       = '0;
        fresh_d        = 1'b0;
        stage_d.status = ST_MOVING;
      end
      ACT_TICK: begin
        if (tsf_q != '1) begin
          tsf_d = tsf_q + 16'd1;
        end
        stage_d.status = ST_IDLE;
        if (phase_q == PH_WAIT) begin
          if (fresh_q) begin
            ref_d     = total_q;
            rel_d     = '0;
            elapsed_d = '0;
            settle_d  = '0;
            phase_d   = PH_MOVE;
          end else begin
            stage_d.cmd_en = 1'b1;
            stage_d.status = ST_MOVING;
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + 24'd1;
            end
            if (elapsed_d >= 24'(FirstFeedbackTicks)) begin
              stage_d.status = ST_NO_FEEDBACK;
              phase_d        = PH_IDLE;
            end
          end
        end
        if (phase_d == PH_MOVE) begin
          stage_d.cmd_en = 1'b1;
          if (stale) begin
            stage_d.status = ST_LOST;
            phase_d        = PH_IDLE;
          end else begin
            stage_d.run_law = 1'b1;
            stage_d.status  = ST_MOVING;
            if (in_band) begin
              if (settle_d != '0 && settle_d >= 17'(cfg_i.settle_ticks)) begin
                reached = 1'b1;
              end else if (settle_d != '1) begin
                settle_d = settle_d + 17'd1;
              end
            end else begin
              settle_d = '0;
            end
            if (reached) begin
              stage_d.status = ST_REACHED;
              phase_d        = PH_IDLE;
            end else if (elapsed_d >= cfg_i.timeout_ticks) begin
              stage_d.status  = ST_TIMEOUT;
              stage_d.run_law = 1'b0;
              phase_d         = PH_IDLE;
            end else if (elapsed_d != '1) begin
              elapsed_d = elapsed_d + 24'd1;
            end
          end
        end
      end
      default: begin
        stage_d.status = (phase_q != PH_IDLE) ? ST_MOVING : ST_IDLE;
      end
    endcase

    stage_d.position = rel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      prev_enc_q <= '0;
      total_q    <= '0;
      ref_q      <= '0;
      rel_q      <= '0;
      rpm_q      <= '0;
      phase_q    <= PH_IDLE;
      target_q   <= '0;
      elapsed_q  <= '0;
      settle_q   <= '0;
      tsf_q      <= '0;
      fresh_q    <= 1'b0;
    end else if (go_i) begin
      tracking_q <= tracking_d;
      prev_enc_q <= prev_enc_d;
      total_q    <= total_d;
      ref_q      <= ref_d;
      rel_q      <= rel_d;
      rpm_q      <= rpm_d;
      phase_q    <= phase_d;
      target_q   <= target_d;
      elapsed_q  <= elapsed_d;
      settle_q   <= settle_d;
      tsf_q      <= tsf_d;
      fresh_q    <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

[hdl/mppd_law.sv]
module mppd_law import mppd_pkg::*; (
  input  stage_t             stage_i,
  input  cfg_t               cfg_i,
  output logic signed [15:0] current_o
);

  localparam logic signed [64:0] PSat = 65'sd1 <<< PSatShift;

  logic signed [CmdW-1:0] p_sat, cmd_pd, cmd_b, cmd_c, bias_q, lim_q, amag;
  logic [16:0]            bias_abs;
  logic [14:0]            lim;
  logic [31:0]            rsum;
  logic [15:0]            rmag;
  logic                   neg;

  always_comb begin
    // Clamp the proportional term; never moves the clipped result
    if (stage_i.p_prod > PSat) begin
      p_sat = CmdW'(PSat);
    end else if (stage_i.p_prod < -PSat) begin
      p_sat = CmdW'(-PSat);
    end else begin
      p_sat = CmdW'(stage_i.p_prod);
    end
    cmd_pd = p_sat - CmdW'(stage_i.d_prod);

    bias_abs = cfg_i.bias_current[15] ? 17'(-{cfg_i.bias_current[15], cfg_i.bias_current})
                                      : {1'b0, cfg_i.bias_current};
    if (bias_abs > 17'(CurrentMax)) begin
      bias_abs = 17'(CurrentMax);
    end
    bias_q = CmdW'({bias_abs, {FracBits{1'b0}}});

    // Push away from zero by the bias while far from target
    cmd_b = cmd_pd;
    if (cfg_i.bias_current != '0 && stage_i.far) begin
      if (cmd_pd[CmdW-1]) begin
        cmd_b = cmd_pd - bias_q;
      end else if (cmd_pd != '0) begin
        cmd_b = cmd_pd + bias_q;
      end else begin
        cmd_b = stage_i.err_pos ? bias_q : -bias_q;
      end
    end

    lim = cfg_i.current_limit;
    if (lim == '0) begin
      lim = 15'd1;
    end else if (lim > 15'(CurrentMax)) begin
      lim = 15'(CurrentMax);
    end
    lim_q = CmdW'({lim, {FracBits{1'b0}}});

    cmd_c = cmd_b;
    if (cmd_b > lim_q) begin
      cmd_c = lim_q;
    end else if (cmd_b < -lim_q) begin
      cmd_c = -lim_q;
    end

    // Round half away from zero
    neg  = cmd_c[CmdW-1];
    amag = neg ? -cmd_c : cmd_c;
    rsum = 32'(amag[30:0]) + (32'd1 << (FracBits - 1));
    rmag = rsum[FracBits+15:FracBits];

    if (!stage_i.run_law) begin
      current_o = '0;
    end else begin
      current_o = neg ? -$signed(rmag) : $signed(rmag);
    end
  end

endmodule
